### src/dq_pkg.sv
`default_nettype none

package dq_pkg;

    localparam int W_KIND   = 3;
    localparam int W_KEY    = 32;
    localparam int W_POS    = 8;
    localparam int W_MATCH  = 4;
    localparam int W_STATUS = 3;
    localparam int W_OCC    = 5;

    // operation codes
    localparam logic [W_KIND-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [W_KIND-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [W_KIND-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [W_KIND-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [W_KIND-1:0] KIND_SEARCH     = 3'd4;
    localparam logic [W_KIND-1:0] KIND_REMOVE     = 3'd5;

    // status codes
    localparam logic [W_STATUS-1:0] ST_OK        = 3'd0;
    localparam logic [W_STATUS-1:0] ST_EMPTY     = 3'd1;
    localparam logic [W_STATUS-1:0] ST_FULL      = 3'd2;
    localparam logic [W_STATUS-1:0] ST_RANGE     = 3'd3;
    localparam logic [W_STATUS-1:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [W_KIND-1:0]       kind;
        logic signed [W_KEY-1:0] key;
        logic [W_POS-1:0]        position;
    } t_item;

    typedef struct packed {
        logic signed [W_KEY-1:0] popped_key;
        logic [W_MATCH-1:0]      match_index;
        logic [W_STATUS-1:0]     status;
        logic [W_OCC-1:0]        occupancy;
    } t_result;

endpackage

`default_nettype wire

### src/dq_ram.sv
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### src/dq_slot.sv
`default_nettype none

// Circular slot arithmetic: (base + offset) mod DEPTH, offset at most DEPTH.
module dq_slot #(
    parameter int DEPTH = 16
) (
    input  wire logic [$clog2(DEPTH)-1:0]   i_base,
    input  wire logic [$clog2(DEPTH+1)-1:0] i_off,
    output logic      [$clog2(DEPTH)-1:0]   o_slot
);

    localparam int W_SLOT = $clog2(DEPTH);
    localparam int W_CNT  = $clog2(DEPTH + 1);
    localparam int W_SUM  = W_CNT + 1;

    logic [W_SUM-1:0] w_sum;
    logic [W_SUM-1:0] w_wrap;

    // sum stays below twice DEPTH, so one compare and subtract wraps it
    assign w_sum  = W_SUM'(i_base) + W_SUM'(i_off);
    assign w_wrap = (w_sum >= W_SUM'(DEPTH)) ? (w_sum - W_SUM'(DEPTH)) : w_sum;
    assign o_slot = w_wrap[W_SLOT-1:0];

endmodule

`default_nettype wire

### src/bounded_deque_search_remove.sv
// Each accepted beat is dispatched in S_DISP: push then writes in S_WRITE; pop reads via
// S_FETCH and S_TAKE; search goes S_FETCH then S_SCAN (1 to DEPTH entries compared); remove
// goes S_FETCH, S_TAKE, then S_MOVE shifts any later entries down; early-out status (full,
// empty, range, unused kind, empty search) comes from S_DISP. One read port walks one entry
// a cycle. busy drops in the strobe cycle, so the next beat follows with no gap; the receiver cannot stall.
// Synchronous active-low reset empties the queue; the entry store itself is not cleared.
`default_nettype none

module bounded_deque_search_remove #(
    parameter int DEPTH = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    input  wire dq_pkg::t_item   i_item,
    output logic                 busy,
    output logic                 o_done,
    output dq_pkg::t_result      o_result
);

    import dq_pkg::*;

    localparam int W_SLOT = $clog2(DEPTH);
    localparam int W_CNT  = $clog2(DEPTH + 1);
    localparam int W_CMP  = (W_CNT > W_POS) ? W_CNT : W_POS;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_WRITE = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_TAKE  = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_MOVE  = 3'd6;

    logic [2:0]        r_state,  n_state;
    t_item             r_item;
    logic [W_SLOT-1:0] r_front,  n_front;
    logic [W_CNT-1:0]  r_count,  n_count;
    logic [W_SLOT-1:0] r_addr,   n_addr;
    logic [W_SLOT-1:0] r_wslot,  n_wslot;
    logic [W_CNT-1:0]  r_idx,    n_idx;
    logic              r_done,   n_done;
    t_result           r_res,    n_res;

    logic [W_CNT-1:0]  w_off0;
    logic [W_SLOT-1:0] w_slot;
    logic              w_we;
    logic [W_SLOT-1:0] w_waddr;
    logic [W_KEY-1:0]  w_wdata;
    logic [W_KEY-1:0]  w_rdata;

    function automatic logic [W_SLOT-1:0] f_inc(input logic [W_SLOT-1:0] s);
        return (s == W_SLOT'(DEPTH - 1)) ? '0 : s + W_SLOT'(1);
    endfunction

    // starting offset from the front for each operation
    always_comb begin
        unique case (r_item.kind)
            KIND_PUSH_FRONT: w_off0 = W_CNT'(DEPTH - 1);
            KIND_PUSH_BACK:  w_off0 = r_count;
            KIND_POP_BACK:   w_off0 = r_count - W_CNT'(1);
            KIND_REMOVE:     w_off0 = W_CNT'(r_item.position);
            default:         w_off0 = '0;
        endcase
    end

    dq_slot #(
        .DEPTH (DEPTH)
    ) u_slot (
        .i_base (r_front),
        .i_off  (w_off0),
        .o_slot (w_slot)
    );

    dq_ram #(
        .WIDTH (W_KEY),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        n_front = r_front;
        n_count = r_count;
        n_addr  = r_addr;
        n_wslot = r_wslot;
        n_idx   = r_idx;
        n_done  = 1'b0;
        n_res   = r_res;
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = r_item.key;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DISP;
                end
            end

            S_DISP: begin
                n_addr = w_slot;
                n_idx  = w_off0;
                n_res  = '0;
                unique case (r_item.kind) inside
                    KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                        if (r_count == W_CNT'(DEPTH)) begin
                            n_res.status = ST_FULL;
                            n_done       = 1'b1;
                        end else begin
                            n_state = S_WRITE;
                        end
                    end
                    KIND_POP_FRONT, KIND_POP_BACK: begin
                        if (r_count == '0) begin
                            n_res.status = ST_EMPTY;
                            n_done       = 1'b1;
                        end else begin
                            n_state = S_FETCH;
                        end
                    end
                    KIND_SEARCH: begin
                        if (r_count == '0) begin
                            n_res.status = ST_NOT_FOUND;
                            n_done       = 1'b1;
                        end else begin
                            n_state = S_FETCH;
                        end
                    end
                    KIND_REMOVE: begin
                        if (W_CMP'(r_item.position) >= W_CMP'(r_count)) begin
                            n_res.status = ST_RANGE;
                            n_done       = 1'b1;
                        end else begin
                            n_state = S_FETCH;
                        end
                    end
                    default: begin
                        // unused kind: report occupancy only
                        n_done = 1'b1;
                    end
                endcase
            end

            S_WRITE: begin
                w_we    = 1'b1;
                w_waddr = r_addr;
                w_wdata = r_item.key;
                if (r_item.kind == KIND_PUSH_FRONT) begin
                    n_front = r_addr;
                end
                n_count = r_count + W_CNT'(1);
                n_done  = 1'b1;
            end

            S_FETCH: begin
                // read of the first entry is in flight; hold its slot, advance the reader
                n_wslot = r_addr;
                n_addr  = f_inc(r_addr);
                n_state = (r_item.kind == KIND_SEARCH) ? S_SCAN : S_TAKE;
            end

            S_TAKE: begin
                n_res.popped_key = w_rdata;
                if (r_item.kind == KIND_POP_FRONT) begin
                    n_front = f_inc(r_front);
                    n_count = r_count - W_CNT'(1);
                    n_done  = 1'b1;
                end else if (r_item.kind == KIND_POP_BACK) begin
                    n_count = r_count - W_CNT'(1);
                    n_done  = 1'b1;
                end else begin
                    n_addr = f_inc(r_addr);
                    if (r_idx + W_CNT'(1) >= r_count) begin
                        n_count = r_count - W_CNT'(1);
                        n_done  = 1'b1;
                    end else begin
                        n_state = S_MOVE;
                    end
                end
            end

            S_MOVE: begin
                // close the gap: entry idx+1 drops into slot of idx
                w_we    = 1'b1;
                w_waddr = r_wslot;
                w_wdata = w_rdata;
                n_wslot = f_inc(r_wslot);
                n_addr  = f_inc(r_addr);
                n_idx   = r_idx + W_CNT'(1);
                if (r_idx + W_CNT'(2) >= r_count) begin
                    n_count = r_count - W_CNT'(1);
                    n_done  = 1'b1;
                end
            end

            S_SCAN: begin
                if (w_rdata == r_item.key) begin
                    n_res.match_index = W_MATCH'(r_idx);
                    n_res.status      = ST_OK;
                    n_done            = 1'b1;
                end else if (r_idx + W_CNT'(1) >= r_count) begin
                    n_res.status = ST_NOT_FOUND;
                    n_done       = 1'b1;
                end else begin
                    n_idx  = r_idx + W_CNT'(1);
                    n_addr = f_inc(r_addr);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (n_done) begin
            n_state         = S_IDLE;
            n_res.occupancy = W_OCC'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_item <= i_item;
        end
        r_addr  <= n_addr;
        r_wslot <= n_wslot;
        r_idx   <= n_idx;
        r_res   <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= W_CNT'(DEPTH))
        else $error("entry count beyond depth");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while sequencer still busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not start the sequencer");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe repeated");
`endif

endmodule

`default_nettype wire
